// ===== rtl/core/nfa_pkg.sv =====
// Shared constants and types for the bit-set automaton matcher.
// No dependencies.
package nfa_pkg;
  localparam int NfaMaxStates  = 64;
  localparam int NfaMaxSymbols = 64;
  localparam int NfaCharCodes  = 128;

  localparam logic [1:0] MODE_MAP   = 2'd0;
  localparam logic [1:0] MODE_TRANS = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STEP  = 2'd3;

  localparam logic [1:0] REG_STATE_COUNT = 2'd0;
  localparam logic [1:0] REG_INITIAL_SET = 2'd1;
  localparam logic [1:0] REG_FINAL_SET   = 2'd2;
  localparam logic [1:0] REG_EPS_CODE    = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch input item, do map lookups
    logic clr_step;   // clear sweep index
    logic rd;         // issue store read at sweep index
    logic acc_next;   // OR read data into successor set
    logic acc_clos;   // OR read data into closure set
    logic begin_clos; // set = masked seed, clear visited
    logic mark;       // mark sweep state visited
    logic wr_rd;      // read row for read-modify-write
    logic wr_wr;      // write modified row
    logic map_wr;     // write symbol map
    logic commit;     // update active set
    logic clr_wr;     // clearing pass write
  } nfa_cmd_t;

  typedef struct packed {
    logic err;        // item rejected
    logic has_eps;    // epsilon mapped
    logic sel_hit;    // sweep state selected
    logic sweep_last; // sweep at last state in use
    logic pass_new;   // closure pass visited something
    logic clr_last;
  } nfa_sts_t;
endpackage

// ===== rtl/core/nfa_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
module nfa_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/core/nfa_dp.sv =====
// Datapath: config registers, symbol map, transition store and set registers.
// Depends on nfa_pkg and nfa_ram.
module nfa_dp import nfa_pkg::*; #(
  parameter int MaxStates  = NfaMaxStates,
  parameter int MaxSymbols = NfaMaxSymbols,
  parameter int CharCodes  = NfaCharCodes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  char_code_i,
  input  logic [5:0]  symbol_index_i,
  input  logic [5:0]  from_state_i,
  input  logic [5:0]  to_state_i,
  input  nfa_cmd_t    cmd_i,
  output nfa_sts_t    sts_o,
  output logic [1:0]  mode_o,
  output logic [63:0] state_set_o,
  output logic        accepted_o
);
  localparam int SW = $clog2(MaxStates);
  localparam int YW = $clog2(MaxSymbols);
  localparam int CW = $clog2(CharCodes);
  localparam int AW = SW + YW;
  localparam int Rows = MaxStates * MaxSymbols;

  logic [6:0]  cnt_q;
  logic [63:0] init_q, fin_q;
  logic [6:0]  eps_q;

  logic [CharCodes-1:0] mv_q;

  logic [1:0]    mode_q;
  logic [6:0]    code_q;
  logic [5:0]    sidx_q, q1_q, q2_q;
  logic [YW-1:0] sym_rd, eps_sym_rd;
  logic          sym_ok_q, eps_ok_q;
  logic [SW-1:0] idx_q;
  logic [AW-1:0] clr_q;
  logic [63:0]   act_q, nxt_q, set_q, vis_q, use_m;
  logic          new_q;
  logic          clos_q;

  logic [6:0]    n_use;
  logic [AW-1:0] addr;
  logic [63:0]   rdata, wdata;
  logic          we;
  logic          code_ok, eps_in, lookup_ok;
  logic          map_we;
  logic [CW-1:0] eps_addr;

  always_comb begin
    n_use = (cnt_q > 7'(MaxStates)) ? 7'(MaxStates) : cnt_q;
    for (int i = 0; i < 64; i++) begin
      use_m[i] = (7'(i) < n_use);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 7'd64;
      init_q <= 64'd1;
      fin_q  <= '0;
      eps_q  <= 7'd38;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STATE_COUNT: cnt_q  <= cfg_data_i[6:0];
        REG_INITIAL_SET: init_q <= cfg_data_i;
        REG_FINAL_SET:   fin_q  <= cfg_data_i;
        REG_EPS_CODE:    eps_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign code_ok = (32'(code_q) < CharCodes);
  assign eps_in  = (32'(eps_q) < CharCodes);
  assign map_we  = cmd_i.map_wr && !mv_q[code_q[CW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= '0;
    end else if (map_we) begin
      mv_q[code_q[CW-1:0]] <= 1'b1;
    end
  end

  // two copies of the symbol map: one looks up the item's code, one the epsilon code
  assign eps_addr = map_we ? code_q[CW-1:0] : eps_q[CW-1:0];

  nfa_ram #(.Width(YW), .Depth(CharCodes)) u_map (
    .clk_i, .we_i(map_we), .addr_i(code_q[CW-1:0]), .wdata_i(sidx_q[YW-1:0]),
    .rdata_o(sym_rd)
  );

  nfa_ram #(.Width(YW), .Depth(CharCodes)) u_eps_map (
    .clk_i, .we_i(map_we), .addr_i(eps_addr), .wdata_i(sidx_q[YW-1:0]),
    .rdata_o(eps_sym_rd)
  );

  // lookups registered in the cycle after the item is latched
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      code_q <= char_code_i;
      sidx_q <= symbol_index_i;
      q1_q   <= from_state_i;
      q2_q   <= to_state_i;
    end
    sym_ok_q  <= code_ok && mv_q[code_q[CW-1:0]];
    eps_ok_q  <= eps_in && mv_q[eps_q[CW-1:0]];
  end

  assign lookup_ok = sym_ok_q;

  always_comb begin
    sts_o = '0;
    case (mode_q)
      MODE_MAP:   sts_o.err = !code_ok || (32'(sidx_q) >= MaxSymbols);
      MODE_TRANS: sts_o.err = !lookup_ok || ({1'b0, q1_q} >= n_use)
                              || ({1'b0, q2_q} >= n_use);
      MODE_STEP:  sts_o.err = !lookup_ok;
      default:    sts_o.err = 1'b0;
    endcase
    sts_o.has_eps    = eps_ok_q;
    sts_o.sel_hit    = (mode_q == MODE_STEP && !clos_q)
                       ? act_q[idx_q] : (set_q[idx_q] && !vis_q[idx_q]);
    sts_o.sweep_last = ({1'b0, idx_q} + 7'd1 >= n_use);
    sts_o.pass_new   = new_q;
    sts_o.clr_last   = (clr_q == AW'(Rows - 1));
  end

  always_comb begin
    we    = 1'b0;
    wdata = rdata | (64'd1 << q2_q);
    addr  = {idx_q, sym_rd};
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      wdata = '0;
      addr  = clr_q;
    end else if (cmd_i.wr_rd || cmd_i.wr_wr) begin
      we    = cmd_i.wr_wr;
      addr  = {q1_q[SW-1:0], sym_rd};
    end else if (cmd_i.acc_clos || mode_q == MODE_START ||
                 (cmd_i.rd && cmd_i.mark)) begin
      addr  = {idx_q, eps_sym_rd};
    end
  end

  nfa_ram #(.Width(64), .Depth(Rows)) u_store (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      clr_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + AW'(1);
      if (cmd_i.clr_step) idx_q <= '0;
      else if (cmd_i.rd) idx_q <= idx_q + SW'(1);
      if (cmd_i.commit) act_q <= set_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) nxt_q <= '0;
    if (cmd_i.acc_next) nxt_q <= nxt_q | rdata;
    if (cmd_i.begin_clos) begin
      set_q <= ((mode_q == MODE_START) ? init_q : nxt_q) & use_m;
      vis_q <= '0;
    end
    if (cmd_i.acc_clos) set_q <= set_q | (rdata & use_m);
    if (cmd_i.mark) vis_q[idx_q] <= 1'b1;
    if (cmd_i.clr_step) new_q <= 1'b0;
    else if (cmd_i.mark) new_q <= 1'b1;
    // closure phase of the item: sweeps select from the closure set
    if (cmd_i.load) clos_q <= 1'b0;
    else if (cmd_i.begin_clos) clos_q <= 1'b1;
  end

  assign mode_o      = mode_q;
  assign state_set_o = act_q;
  assign accepted_o  = |(act_q & fin_q);
endmodule

// ===== rtl/core/nfa_ctrl.sv =====
// Controller: sequences item handling, store sweeps and closure passes.
// Depends on nfa_pkg.
module nfa_ctrl import nfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic [1:0] mode_i,
  input  nfa_sts_t   sts_i,
  output nfa_cmd_t   cmd_o,
  output logic       err_o
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_WWR   = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SACC  = 4'd7;
  localparam logic [3:0] S_CBEG  = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_CACC  = 4'd10;
  localparam logic [3:0] S_CEND  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_WAIT  = 4'd13;

  logic [3:0] st_q, st_d;
  logic       err_q, err_d, ov_q, ov_d;

  always_comb begin
    st_d  = st_q;
    err_d = err_q;
    ov_d  = ov_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) st_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = S_LOOK;
        end
      end
      S_LOOK: st_d = S_DEC;
      S_DEC: begin
        err_d = sts_i.err;
        cmd_o.clr_step = 1'b1;
        if (sts_i.err) st_d = S_WAIT;
        else begin
          case (mode_i)
            MODE_MAP:   begin cmd_o.map_wr = 1'b1; st_d = S_WAIT; end
            MODE_TRANS: st_d = S_WRD;
            MODE_START: st_d = S_CBEG;
            default:    st_d = S_SRD;
          endcase
        end
      end
      S_WRD: begin cmd_o.wr_rd = 1'b1; st_d = S_WWR; end
      S_WWR: begin cmd_o.wr_wr = 1'b1; st_d = S_WAIT; end
      S_SRD: begin
        if (sts_i.sel_hit) begin
          st_d = S_SACC;
        end else begin
          cmd_o.rd = 1'b1;
          if (sts_i.sweep_last) begin
            cmd_o.clr_step = 1'b1;
            st_d = S_CBEG;
          end
        end
      end
      S_SACC: begin
        cmd_o.acc_next = 1'b1;
        cmd_o.rd = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.clr_step = 1'b1;
          st_d = S_CBEG;
        end else st_d = S_SRD;
      end
      S_CBEG: begin
        cmd_o.begin_clos = 1'b1;
        cmd_o.clr_step = 1'b1;
        st_d = sts_i.has_eps ? S_CRD : S_CEND;
      end
      S_CRD: begin
        if (sts_i.sel_hit) begin
          cmd_o.mark = 1'b1;
          cmd_o.rd = 1'b1;
          st_d = S_CACC;
        end else begin
          cmd_o.rd = 1'b1;
          if (sts_i.sweep_last) begin
            if (sts_i.pass_new) cmd_o.clr_step = 1'b1;
            else st_d = S_CEND;
            if (sts_i.pass_new) st_d = S_CRD;
          end
        end
      end
      S_CACC: begin
        cmd_o.acc_clos = 1'b1;
        // idx already advanced past the marked state
        if (sts_i.sweep_last && 1'b0) st_d = S_CEND;
        st_d = S_CRD;
      end
      S_CEND: begin cmd_o.commit = 1'b1; st_d = S_WAIT; end
      S_WAIT: st_d = S_OUT;
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLR;
      err_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      err_q <= err_d;
      ov_q  <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign err_o       = err_q;
endmodule

// ===== rtl/core/nfa_bitset_step.sv =====
// Top level of the bit-set automaton matcher.
// Depends on nfa_pkg, nfa_ctrl, nfa_dp and nfa_ram.
// One item at a time; in_ready_o is high only while idle. A map write or a rejected item
// completes after lookup and decode, and a transition add after a read-modify-write of
// its store row. A start builds the closure of the initial set; a step sweeps the states
// in use, ORs the rows of the active states into the successor set, then builds its
// closure. With an epsilon symbol mapped, the closure runs passes over the states in use,
// reading the row of each state reached, until a pass reaches nothing new, so at least two
// passes once the seed set is not empty. A result waits in the output register until taken.
// After reset a clearing pass zeroes all MaxStates*MaxSymbols store rows before the first
// transfer; configuration writes are taken throughout.
module nfa_bitset_step import nfa_pkg::*; #(
  parameter int MaxStates  = NfaMaxStates,
  parameter int MaxSymbols = NfaMaxSymbols,
  parameter int CharCodes  = NfaCharCodes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  char_code_i,
  input  logic [5:0]  symbol_index_i,
  input  logic [5:0]  from_state_i,
  input  logic [5:0]  to_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] state_set_o,
  output logic        accepted_o,
  output logic        error_o
);
  nfa_cmd_t   cmd;
  nfa_sts_t   sts;
  logic [1:0] mode;
  logic [63:0] set_w;
  logic        acc_w;
  logic        err_w;
  logic [63:0] set_q;
  logic        acc_q;
  logic        err_q;

  nfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .mode_i(mode), .sts_i(sts), .cmd_o(cmd), .err_o(err_w)
  );

  nfa_dp #(.MaxStates(MaxStates), .MaxSymbols(MaxSymbols), .CharCodes(CharCodes)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mode_i, .char_code_i, .symbol_index_i, .from_state_i, .to_state_i,
    .cmd_i(cmd), .sts_o(sts), .mode_o(mode), .state_set_o(set_w), .accepted_o(acc_w)
  );

  // output register, loaded as the result is presented
  always_ff @(posedge clk_i) begin
    if (!out_valid_o || out_ready_i) begin
      set_q <= set_w;
      acc_q <= acc_w;
      err_q <= err_w;
    end
  end

  assign state_set_o = set_q;
  assign accepted_o  = acc_q;
  assign error_o     = err_q;
endmodule
